/* design/pai_pkg.sv */
// Package for the photo attribute image extractor.
// Holds the parser phase type, status and format codes, byte constants and
// the result struct. It depends on nothing else.
package pai_pkg;

    typedef enum logic [3:0] {
        PH_LEN0  = 4'd0,
        PH_LEN2  = 4'd1,
        PH_LEN5  = 4'd2,
        PH_TYPE  = 4'd3,
        PH_HDR   = 4'd4,
        PH_HSKIP = 4'd5,
        PH_IMG   = 4'd6,
        PH_SKIP  = 4'd7,
        PH_DONE  = 4'd8,
        PH_ERR   = 4'd9
    } phase_t;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_JPEG    = 2'd1;
    localparam logic [1:0] FMT_PNG     = 2'd2;

    localparam logic [7:0] LEN_TWO_BYTE  = 8'd192;
    localparam logic [7:0] LEN_PARTIAL   = 8'd224;
    localparam logic [7:0] LEN_FIVE_BYTE = 8'd255;
    localparam logic [7:0] SUBPKT_IMAGE  = 8'd1;

    localparam logic [7:0] JPEG_B0 = 8'hFF;
    localparam logic [7:0] JPEG_B1 = 8'hD8;
    localparam logic [7:0] JPEG_B2 = 8'hFF;
    localparam logic [7:0] PNG_B0  = 8'h89;
    localparam logic [7:0] PNG_B1  = 8'h50;
    localparam logic [7:0] PNG_B2  = 8'h4E;
    localparam logic [7:0] PNG_B3  = 8'h47;

    localparam logic [2:0] SEEN_MAX = 3'd4;

    typedef struct packed {
        logic       has_result;
        logic       byte_valid;
        logic [7:0] image_byte;
        logic       done_res;
        logic [1:0] status;
        logic [1:0] format;
    } pai_result_t;

endpackage

/* design/pai_parser.sv */
// Subpacket walker of the photo attribute image extractor.
// Holds the parse state and computes the result of one byte; uses pai_pkg.
module pai_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output pai_pkg::pai_result_t res
);

    pai_pkg::phase_t phase_reg, phase_next;
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] sub_left_reg, sub_left_next;
    logic [7:0]  hskip_reg, hskip_next;
    logic [2:0]  seen_reg, seen_next;
    logic [1:0]  fmt_reg, fmt_next;

    logic [31:0] sub_dec;
    logic [31:0] byte_wide;
    logic [31:0] body_len;
    logic        byte_valid;
    logic [1:0]  fmt_cls;
    logic [2:0]  seen_cls;

    assign sub_dec   = sub_left_reg - 32'd1;
    assign byte_wide = {24'd0, in_byte};

    // Format guess from the leading image bytes.
    always_comb begin
        fmt_cls  = fmt_reg;
        seen_cls = seen_reg;
        case (seen_reg)
            3'd0: begin
                if (in_byte == pai_pkg::JPEG_B0) begin
                    fmt_cls = pai_pkg::FMT_JPEG;
                end else if (in_byte == pai_pkg::PNG_B0) begin
                    fmt_cls = pai_pkg::FMT_PNG;
                end else begin
                    fmt_cls = pai_pkg::FMT_UNKNOWN;
                end
            end
            3'd1: begin
                if ((fmt_reg == pai_pkg::FMT_JPEG && in_byte != pai_pkg::JPEG_B1) ||
                    (fmt_reg == pai_pkg::FMT_PNG && in_byte != pai_pkg::PNG_B1)) begin
                    fmt_cls = pai_pkg::FMT_UNKNOWN;
                end
            end
            3'd2: begin
                if ((fmt_reg == pai_pkg::FMT_JPEG && in_byte != pai_pkg::JPEG_B2) ||
                    (fmt_reg == pai_pkg::FMT_PNG && in_byte != pai_pkg::PNG_B2)) begin
                    fmt_cls = pai_pkg::FMT_UNKNOWN;
                end
            end
            3'd3: begin
                if (fmt_reg == pai_pkg::FMT_PNG && in_byte != pai_pkg::PNG_B3) begin
                    fmt_cls = pai_pkg::FMT_UNKNOWN;
                end
            end
            default: begin
                fmt_cls = fmt_reg;
            end
        endcase
        if (seen_reg < pai_pkg::SEEN_MAX) begin
            seen_cls = seen_reg + 3'd1;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        len_left_next = len_left_reg;
        sub_left_next = sub_left_reg;
        hskip_next    = hskip_reg;
        seen_next     = seen_reg;
        fmt_next      = fmt_reg;
        byte_valid    = 1'b0;
        body_len      = 32'd0;

        case (phase_reg)
            pai_pkg::PH_LEN0: begin
                if (in_byte < pai_pkg::LEN_TWO_BYTE) begin
                    if (in_byte == 8'd0) begin
                        phase_next = pai_pkg::PH_ERR;
                    end else begin
                        sub_left_next = byte_wide;
                        phase_next    = pai_pkg::PH_TYPE;
                    end
                end else if (in_byte < pai_pkg::LEN_PARTIAL) begin
                    // The first byte is 192..223, so its offset fits in five bits.
                    accum_next = {19'd0, in_byte[4:0], 8'd0};
                    phase_next = pai_pkg::PH_LEN2;
                end else if (in_byte == pai_pkg::LEN_FIVE_BYTE) begin
                    accum_next    = 32'd0;
                    len_left_next = 3'd4;
                    phase_next    = pai_pkg::PH_LEN5;
                end else begin
                    phase_next = pai_pkg::PH_ERR;
                end
            end
            pai_pkg::PH_LEN2: begin
                body_len = accum_reg + byte_wide + {24'd0, pai_pkg::LEN_TWO_BYTE};
                if (body_len == 32'd0) begin
                    phase_next = pai_pkg::PH_ERR;
                end else begin
                    sub_left_next = body_len;
                    phase_next    = pai_pkg::PH_TYPE;
                end
            end
            pai_pkg::PH_LEN5: begin
                body_len      = {accum_reg[23:0], in_byte};
                accum_next    = body_len;
                len_left_next = len_left_reg - 3'd1;
                if (len_left_next == 3'd0) begin
                    if (body_len == 32'd0) begin
                        phase_next = pai_pkg::PH_ERR;
                    end else begin
                        sub_left_next = body_len;
                        phase_next    = pai_pkg::PH_TYPE;
                    end
                end
            end
            pai_pkg::PH_TYPE: begin
                sub_left_next = sub_dec;
                if (in_byte == pai_pkg::SUBPKT_IMAGE && sub_dec != 32'd0) begin
                    phase_next = pai_pkg::PH_HDR;
                end else if (sub_dec == 32'd0) begin
                    phase_next = pai_pkg::PH_LEN0;
                end else begin
                    phase_next = pai_pkg::PH_SKIP;
                end
            end
            pai_pkg::PH_HDR: begin
                // The remaining count still includes this header length byte.
                if (in_byte == 8'd0 || byte_wide > sub_left_reg) begin
                    phase_next = pai_pkg::PH_ERR;
                end else if ((sub_left_reg - byte_wide) >= 32'd3) begin
                    sub_left_next = sub_dec;
                    hskip_next    = in_byte - 8'd1;
                    phase_next    = (in_byte == 8'd1) ? pai_pkg::PH_IMG : pai_pkg::PH_HSKIP;
                end else begin
                    sub_left_next = sub_dec;
                    phase_next    = (sub_dec == 32'd0) ? pai_pkg::PH_LEN0 : pai_pkg::PH_SKIP;
                end
            end
            pai_pkg::PH_HSKIP: begin
                sub_left_next = sub_dec;
                hskip_next    = hskip_reg - 8'd1;
                if (hskip_next == 8'd0) begin
                    phase_next = pai_pkg::PH_IMG;
                end
            end
            pai_pkg::PH_IMG: begin
                byte_valid    = 1'b1;
                fmt_next      = fmt_cls;
                seen_next     = seen_cls;
                sub_left_next = sub_dec;
                if (sub_dec == 32'd0) begin
                    // A PNG signature needs all four bytes.
                    if (fmt_cls == pai_pkg::FMT_PNG && seen_cls < pai_pkg::SEEN_MAX) begin
                        fmt_next = pai_pkg::FMT_UNKNOWN;
                    end
                    phase_next = pai_pkg::PH_DONE;
                end
            end
            pai_pkg::PH_SKIP: begin
                sub_left_next = sub_dec;
                if (sub_dec == 32'd0) begin
                    phase_next = pai_pkg::PH_LEN0;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb begin
        res.has_result = byte_valid | in_last;
        res.byte_valid = byte_valid;
        res.image_byte = byte_valid ? in_byte : 8'd0;
        res.done_res   = in_last;
        res.status     = pai_pkg::STATUS_FOUND;
        res.format     = pai_pkg::FMT_UNKNOWN;
        if (in_last) begin
            if (phase_next == pai_pkg::PH_DONE) begin
                res.format = fmt_next;
            end else if (phase_next == pai_pkg::PH_LEN0) begin
                res.status = pai_pkg::STATUS_NONE;
            end else begin
                res.status = pai_pkg::STATUS_BAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_last)) begin
            phase_reg    <= pai_pkg::PH_LEN0;
            accum_reg    <= 32'd0;
            len_left_reg <= 3'd0;
            sub_left_reg <= 32'd0;
            hskip_reg    <= 8'd0;
            seen_reg     <= 3'd0;
            fmt_reg      <= pai_pkg::FMT_UNKNOWN;
        end else if (step) begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            len_left_reg <= len_left_next;
            sub_left_reg <= sub_left_next;
            hskip_reg    <= hskip_next;
            seen_reg     <= seen_next;
            fmt_reg      <= fmt_next;
        end
    end

endmodule

/* design/photo_attribute_image_extractor.sv */
// Path: a byte accepted on the slave side enters the input register; the parser's result
// for it is registered in the result register, which drives the master side. Throughput:
// one byte per cycle while the result slot is free; a byte with a result waits while the
// master side stalls. A byte that produces no result never waits on the master side.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of a packet; it also returns there after each last byte.
module photo_attribute_image_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] image_byte, [9:8] status, [11:10] format, zeros
    output logic [0:0]  m_tuser,   // [0] byte_valid
    output logic        m_tlast    // done_res
);

    // Input register: one packet byte waiting for the parser.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register: one result transaction waiting for the consumer.
    logic       out_valid_reg;
    logic       out_bvalid_reg;
    logic [7:0] out_byte_reg;
    logic       out_done_reg;
    logic [1:0] out_status_reg;
    logic [1:0] out_format_reg;

    pai_pkg::pai_result_t res;
    logic out_free;
    logic advance;

    // The result slot is free when empty or when its transaction completes now.
    assign out_free = !out_valid_reg || m_tready;
    // A byte without a result is consumed at once; otherwise it needs the slot.
    assign advance  = in_valid_reg && (!res.has_result || out_free);
    assign s_tready = !in_valid_reg || advance;

    pai_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_bvalid_reg <= res.byte_valid;
            out_byte_reg   <= res.image_byte;
            out_done_reg   <= res.done_res;
            out_status_reg <= res.status;
            out_format_reg <= res.format;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_format_reg, out_status_reg, out_byte_reg};
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_done_reg;

endmodule

/* design/pai_checker.sv */
// Port-level checks for the photo attribute image extractor, bound to the top.
// Depends only on the top level's ports.
module pai_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result transaction holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A result without an image byte exists only to report the packet end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("empty result that is not a packet end");

    // Status and format stay zero before the packet end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[11:8] == 4'd0)
        else $error("status or format set before packet end");

    // A format is reported only with a found image, and status 3 never occurs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[9:8] != 2'd0 |->
            m_tdata[11:10] == 2'd0 && m_tdata[9:8] != 2'd3)
        else $error("format without found image or bad status code");

endmodule

bind photo_attribute_image_extractor pai_checker u_pai_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
